@@ hdl/pes_pkg.sv @@
// ----------------------------------------------------------------------------
// pes_pkg: shared types and constants of the priority event scheduler
// Store geometry, function codes, slot and write-request structs.
// ----------------------------------------------------------------------------
package pes_pkg;

   localparam int MAX_EVENTS    = 64;
   localparam int PRIORITY_BITS = 8;
   localparam int ID_W          = 6;
   localparam int ID_COUNT      = 1 << ID_W;
   localparam int ADDR_W        = $clog2(MAX_EVENTS);
   localparam int CNT_W         = $clog2(MAX_EVENTS + 1);
   localparam int RUN_W         = PRIORITY_BITS + 1;

   localparam logic [1:0] FUNC_POST     = 2'd0;
   localparam logic [1:0] FUNC_CANCEL   = 2'd1;
   localparam logic [1:0] FUNC_DISPATCH = 2'd2;
   localparam logic [1:0] FUNC_RESTORE  = 2'd3;

   localparam logic [PRIORITY_BITS-1:0] IMMED_RESET = '1;

   typedef struct packed {
      logic [ID_W-1:0]          ev_id;
      logic [PRIORITY_BITS-1:0] level;
   } slot_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      slot_type          data;
   } wr_req_type;

endpackage

@@ hdl/pes_store.sv @@
// ----------------------------------------------------------------------------
// pes_store: ordered slot memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pes_store (
   input  logic                      clock,
   input  pes_pkg::wr_req_type       wr,
   input  logic [pes_pkg::ADDR_W-1:0] rd_addr,
   output pes_pkg::slot_type         rd_data
);
   import pes_pkg::*;

   slot_type mem [MAX_EVENTS];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/priority_event_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// priority_event_scheduler_unit: priority-ordered event queue
// Keeps event ids sorted by descending priority, FIFO among equal priorities,
// in one slot memory walked by a small sequencer.
//
//   channel   ports                                   handshake
//   request   req_func/event_id/priority_req/caller_* start & !busy
//   response  rsp_accepted ... rsp_busy_res           rsp_valid, one cycle
//   config    csr_wr_data                             csr_wr_en
//
// Restore, immediate and rejected posts, cancel of an id not queued and
// dispatch on an empty queue finish straight from idle, and a dispatch whose
// head does not outrank the caller ends in the head check. A post walks from
// the tail down to its slot, while a cancel and a popping dispatch scan the
// whole queue, each slot read in a RD state and moved in the EV state after.
// The beat shows on rsp_valid in the cycle after the last work cycle. Reset is
// synchronous and clears the queue at once. The receiver cannot stall; busy
// holds off new requests while work is active.
// ----------------------------------------------------------------------------
module priority_event_scheduler_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_func,
   input  logic [pes_pkg::ID_W-1:0]          req_event_id,
   input  logic [pes_pkg::PRIORITY_BITS-1:0] req_priority_req,
   input  logic signed [pes_pkg::RUN_W-1:0]  req_caller_priority,
   output logic                              rsp_valid,
   output logic                              rsp_accepted,
   output logic                              rsp_immediate,
   output logic                              rsp_preempt_request,
   output logic                              rsp_found,
   output logic [pes_pkg::ID_W-1:0]          rsp_out_event_id,
   output logic [pes_pkg::PRIORITY_BITS-1:0] rsp_out_priority,
   output logic                              rsp_busy_res,
   input  logic                              csr_wr_en,
   input  logic [pes_pkg::PRIORITY_BITS-1:0] csr_wr_data
);
   import pes_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_INS_RD  = 6'b000010,
      ST_INS_EV  = 6'b000100,
      ST_HEAD_EV = 6'b001000,
      ST_SCAN_RD = 6'b010000,
      ST_SCAN_EV = 6'b100000
   } state_type;

   typedef struct packed {
      logic                     accepted;
      logic                     immediate;
      logic                     preempt;
      logic                     found;
      logic [ID_W-1:0]          ev_id;
      logic [PRIORITY_BITS-1:0] prio;
      logic                     busy_res;
   } res_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     hit_ff, hit_in;
   logic [1:0]               func_ff, func_in;
   logic [ID_W-1:0]          id_ff, id_in;
   logic [PRIORITY_BITS-1:0] prio_ff, prio_in;
   logic signed [RUN_W-1:0]  caller_ff, caller_in;
   logic [ID_COUNT-1:0]      queued_ff, queued_in;
   logic signed [RUN_W-1:0]  running_ff, running_in;
   logic                     pending_ff, pending_in;
   logic [PRIORITY_BITS-1:0] immed_ff, immed_in;
   res_type                  res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   wr_req_type               wr;
   logic [ADDR_W-1:0]        rd_addr;
   slot_type                 rd_data;
   logic [CNT_W-1:0]         idx_dec;
   logic [CNT_W-1:0]         count_dec;

   pes_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign idx_dec   = idx_ff - CNT_W'(1);
   assign count_dec = count_ff - CNT_W'(hit_ff);

   // Head is prefetched while idle so a dispatch sees slot 0 next cycle.
   always_comb begin
      if (state_ff == ST_INS_RD) begin
         rd_addr = idx_dec[ADDR_W-1:0];
      end else if (state_ff == ST_SCAN_RD) begin
         rd_addr = idx_ff[ADDR_W-1:0];
      end else begin
         rd_addr = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      hit_in       = hit_ff;
      func_in      = func_ff;
      id_in        = id_ff;
      prio_in      = prio_ff;
      caller_in    = caller_ff;
      queued_in    = queued_ff;
      running_in   = running_ff;
      pending_in   = pending_ff;
      immed_in     = csr_wr_en ? csr_wr_data : immed_ff;
      res_in       = res_ff;
      rsp_valid_in = 1'b0;
      wr           = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in         = req_func;
               id_in           = req_event_id;
               prio_in         = req_priority_req;
               caller_in       = req_caller_priority;
               res_in          = '0;
               res_in.busy_res = (count_ff != '0);
               case (req_func)
                  FUNC_POST: begin
                     if (req_priority_req == immed_ff) begin
                        res_in.immediate = 1'b1;
                        rsp_valid_in     = 1'b1;
                     end else if (queued_ff[req_event_id] ||
                                  count_ff == CNT_W'(MAX_EVENTS)) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        queued_in[req_event_id] = 1'b1;
                        res_in.accepted         = 1'b1;
                        res_in.busy_res         = 1'b1;
                        if ($signed({1'b0, req_priority_req}) > running_ff &&
                            !pending_ff) begin
                           pending_in     = 1'b1;
                           res_in.preempt = 1'b1;
                        end
                        idx_in   = count_ff;
                        state_in = ST_INS_RD;
                     end
                  end
                  FUNC_CANCEL: begin
                     if (!queued_ff[req_event_id]) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        queued_in[req_event_id] = 1'b0;
                        res_in.accepted         = 1'b1;
                        idx_in                  = '0;
                        hit_in                  = 1'b0;
                        state_in                = ST_SCAN_RD;
                     end
                  end
                  FUNC_DISPATCH: begin
                     pending_in = 1'b0;
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_HEAD_EV;
                     end
                  end
                  default: begin
                     running_in   = req_caller_priority;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_INS_RD: begin
            if (idx_ff == '0) begin
               wr.en        = 1'b1;
               wr.addr      = '0;
               wr.data      = '{ev_id: id_ff, level: prio_ff};
               count_in     = count_ff + CNT_W'(1);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_INS_EV;
            end
         end
         ST_INS_EV: begin
            wr.en   = 1'b1;
            wr.addr = idx_ff[ADDR_W-1:0];
            if (rd_data.level < prio_ff) begin
               // shift the lower-priority slot one place toward the tail
               wr.data  = rd_data;
               idx_in   = idx_dec;
               state_in = ST_INS_RD;
            end else begin
               wr.data      = '{ev_id: id_ff, level: prio_ff};
               count_in     = count_ff + CNT_W'(1);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_HEAD_EV: begin
            if ($signed({1'b0, rd_data.level}) > caller_ff) begin
               res_in.found             = 1'b1;
               res_in.ev_id             = rd_data.ev_id;
               res_in.prio              = rd_data.level;
               queued_in[rd_data.ev_id] = 1'b0;
               running_in               = $signed({1'b0, rd_data.level});
               hit_in                   = 1'b1;
               idx_in                   = CNT_W'(1);
               state_in                 = ST_SCAN_RD;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               count_in        = count_dec;
               res_in.busy_res = (count_dec != '0);
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               state_in = ST_SCAN_EV;
            end
         end
         ST_SCAN_EV: begin
            if (hit_ff) begin
               // close the gap left by the removed slot
               wr.en   = 1'b1;
               wr.addr = idx_dec[ADDR_W-1:0];
               wr.data = rd_data;
            end else if (func_ff == FUNC_CANCEL && rd_data.ev_id == id_ff) begin
               hit_in = 1'b1;
            end
            idx_in   = idx_ff + CNT_W'(1);
            state_in = ST_SCAN_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         queued_ff    <= '0;
         running_ff   <= '1;
         pending_ff   <= 1'b0;
         immed_ff     <= IMMED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         queued_ff    <= queued_in;
         running_ff   <= running_in;
         pending_ff   <= pending_in;
         immed_ff     <= immed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      hit_ff    <= hit_in;
      func_ff   <= func_in;
      id_ff     <= id_in;
      prio_ff   <= prio_in;
      caller_ff <= caller_in;
      res_ff    <= res_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = res_ff.accepted;
   assign rsp_immediate       = res_ff.immediate;
   assign rsp_preempt_request = res_ff.preempt;
   assign rsp_found           = res_ff.found;
   assign rsp_out_event_id    = res_ff.ev_id;
   assign rsp_out_priority    = res_ff.prio;
   assign rsp_busy_res        = res_ff.busy_res;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_EVENTS))
      else $error("queue depth above store size");

   a_beat_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE)
      else $error("response beat while work is active");

   a_queued_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> $countones(queued_ff) == int'(count_ff))
      else $error("queued map disagrees with queue depth");

   a_found_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.found |-> !res_ff.accepted && !res_ff.immediate)
      else $error("dispatch beat mixes post or cancel flags");

   a_preempt_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.preempt |-> pending_ff)
      else $error("preempt reported without a pending request");

endmodule

@@ bench/pes_queue_checker.sv @@
// ----------------------------------------------------------------------------
// pes_queue_checker: response checker for the priority event scheduler
// Mirrors the ordered event store, running level and preempt flag, predicts
// one response per request taken and compares it field by field with
// the response beats in order of arrival.
// ----------------------------------------------------------------------------
module pes_queue_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [1:0]                        req_func,
   input  logic [pes_pkg::ID_W-1:0]          req_event_id,
   input  logic [pes_pkg::PRIORITY_BITS-1:0] req_priority_req,
   input  logic signed [pes_pkg::RUN_W-1:0]  req_caller_priority,
   input  logic                              rsp_valid,
   input  logic                              rsp_accepted,
   input  logic                              rsp_immediate,
   input  logic                              rsp_preempt_request,
   input  logic                              rsp_found,
   input  logic [pes_pkg::ID_W-1:0]          rsp_out_event_id,
   input  logic [pes_pkg::PRIORITY_BITS-1:0] rsp_out_priority,
   input  logic                              rsp_busy_res,
   input  logic                              csr_wr_en,
   input  logic [pes_pkg::PRIORITY_BITS-1:0] csr_wr_data,
   output int                                error_count,
   output int                                outstanding,
   output int                                checked,
   output int                                popped,
   output int                                immediates
);
   timeunit 1ns;
   timeprecision 1ps;
   import pes_pkg::*;

   typedef struct packed {
      logic                     accepted;
      logic                     immediate;
      logic                     preempt;
      logic                     found;
      logic [ID_W-1:0]          ev_id;
      logic [PRIORITY_BITS-1:0] level;
      logic                     busy;
   } outcome_type;

   // shadow of the ordered store, head at line 0
   logic [ID_W-1:0]          line_id  [MAX_EVENTS];
   logic [PRIORITY_BITS-1:0] line_lvl [MAX_EVENTS];
   int                       line_count;
   logic [ID_COUNT-1:0]      id_listed;
   logic signed [RUN_W-1:0]  running_lvl;
   logic                     preempt_raised;
   logic [PRIORITY_BITS-1:0] immed_lvl;

   outcome_type awaited[$];
   int n_err = 0;
   int n_chk = 0;
   int n_pop = 0;
   int n_imm = 0;

   function automatic void drop_line(int pos);
      for (int i = pos; i + 1 < line_count; i++) begin
         line_id[i]  = line_id[i + 1];
         line_lvl[i] = line_lvl[i + 1];
      end
      line_count--;
   endfunction

   function automatic outcome_type schedule_step(logic [1:0] fn, logic [ID_W-1:0] id,
                                                 logic [PRIORITY_BITS-1:0] lvl,
                                                 logic signed [RUN_W-1:0] caller);
      outcome_type o;
      int          pos;
      o = '0;
      case (fn)
         FUNC_POST: begin
            if (lvl == immed_lvl) begin
               o.immediate = 1'b1;
            end else if (!id_listed[id] && line_count < MAX_EVENTS) begin
               // insert behind every entry of equal or higher level
               pos = 0;
               while (pos < line_count && line_lvl[pos] >= lvl) pos++;
               for (int i = line_count; i > pos; i--) begin
                  line_id[i]  = line_id[i - 1];
                  line_lvl[i] = line_lvl[i - 1];
               end
               line_id[pos]  = id;
               line_lvl[pos] = lvl;
               line_count++;
               id_listed[id] = 1'b1;
               o.accepted    = 1'b1;
               if ($signed({1'b0, lvl}) > running_lvl && !preempt_raised) begin
                  preempt_raised = 1'b1;
                  o.preempt      = 1'b1;
               end
            end
         end
         FUNC_CANCEL: begin
            if (id_listed[id]) begin
               pos = 0;
               while (pos < line_count && line_id[pos] != id) pos++;
               if (pos < line_count) drop_line(pos);
               id_listed[id] = 1'b0;
               o.accepted    = 1'b1;
            end
         end
         FUNC_DISPATCH: begin
            preempt_raised = 1'b0;
            if (line_count > 0 && $signed({1'b0, line_lvl[0]}) > caller) begin
               o.found     = 1'b1;
               o.ev_id     = line_id[0];
               o.level     = line_lvl[0];
               running_lvl = $signed({1'b0, line_lvl[0]});
               id_listed[line_id[0]] = 1'b0;
               drop_line(0);
            end
         end
         FUNC_RESTORE: begin
            running_lvl = caller;
         end
      endcase
      o.busy = (line_count > 0);
      return o;
   endfunction

   function automatic void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         n_err++;
      end
   endfunction

   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (reset) begin
         line_count     = 0;
         id_listed      = '0;
         running_lvl    = '1;
         preempt_raised = 1'b0;
         immed_lvl      = IMMED_RESET;
         awaited.delete();
      end else begin
         // retire the response first: a request taken at this edge is newer
         if (rsp_valid) begin
            got = '{rsp_accepted, rsp_immediate, rsp_preempt_request, rsp_found,
                    rsp_out_event_id, rsp_out_priority, rsp_busy_res};
            if (awaited.size() == 0) begin
               $error("response beat with no request outstanding");
               n_err++;
            end else begin
               want = awaited.pop_front();
               n_chk++;
               compare_field("accepted", 8'(want.accepted), 8'(got.accepted));
               compare_field("immediate", 8'(want.immediate), 8'(got.immediate));
               compare_field("preempt_request", 8'(want.preempt), 8'(got.preempt));
               compare_field("found", 8'(want.found), 8'(got.found));
               compare_field("out_event_id", 8'(want.ev_id), 8'(got.ev_id));
               compare_field("out_priority", want.level, got.level);
               compare_field("busy_res", 8'(want.busy), 8'(got.busy));
               if (want.found) n_pop++;
               if (want.immediate) n_imm++;
            end
         end
         if (csr_wr_en) immed_lvl = csr_wr_data;
         if (start && !busy)
            awaited.push_back(schedule_step(req_func, req_event_id, req_priority_req,
                                            req_caller_priority));
      end
      error_count <= n_err;
      outstanding <= awaited.size();
      checked     <= n_chk;
      popped      <= n_pop;
      immediates  <= n_imm;
   end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for priority_event_scheduler_unit
// Directed corner requests, then phases of random post, cancel, dispatch and
// restore traffic under different immediate levels, with store fills, random
// sender gaps and drains between phases. Checking sits in pes_queue_checker.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pes_pkg::*;

   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 200;
   localparam int STALL_LIMIT = 2000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic [1:0]                     req_func = FUNC_POST;
   logic [ID_W-1:0]                req_event_id = '0;
   logic [PRIORITY_BITS-1:0]       req_priority_req = '0;
   logic signed [RUN_W-1:0]        req_caller_priority = '0;
   logic                           rsp_valid;
   logic                           rsp_accepted;
   logic                           rsp_immediate;
   logic                           rsp_preempt_request;
   logic                           rsp_found;
   logic [ID_W-1:0]                rsp_out_event_id;
   logic [PRIORITY_BITS-1:0]       rsp_out_priority;
   logic                           rsp_busy_res;
   logic                           csr_wr_en = 1'b0;
   logic [PRIORITY_BITS-1:0]       csr_wr_data = '0;

   int error_count;
   int outstanding;
   int checked;
   int popped;
   int immediates;

   int                       n_sent = 0;
   int                       n_levels = 0;
   int                       n_fills = 0;
   int                       stall_cycles = 0;
   int                       idle_pct = 0;
   int                       post_pct;
   int                       cancel_pct;
   int                       dispatch_pct;
   logic                     narrow;
   logic [PRIORITY_BITS-1:0] band_base;
   logic [PRIORITY_BITS-1:0] immed_now = IMMED_RESET;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   priority_event_scheduler_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_func            (req_func),
      .req_event_id        (req_event_id),
      .req_priority_req    (req_priority_req),
      .req_caller_priority (req_caller_priority),
      .rsp_valid           (rsp_valid),
      .rsp_accepted        (rsp_accepted),
      .rsp_immediate       (rsp_immediate),
      .rsp_preempt_request (rsp_preempt_request),
      .rsp_found           (rsp_found),
      .rsp_out_event_id    (rsp_out_event_id),
      .rsp_out_priority    (rsp_out_priority),
      .rsp_busy_res        (rsp_busy_res),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   pes_queue_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_func            (req_func),
      .req_event_id        (req_event_id),
      .req_priority_req    (req_priority_req),
      .req_caller_priority (req_caller_priority),
      .rsp_valid           (rsp_valid),
      .rsp_accepted        (rsp_accepted),
      .rsp_immediate       (rsp_immediate),
      .rsp_preempt_request (rsp_preempt_request),
      .rsp_found           (rsp_found),
      .rsp_out_event_id    (rsp_out_event_id),
      .rsp_out_priority    (rsp_out_priority),
      .rsp_busy_res        (rsp_busy_res),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .error_count         (error_count),
      .outstanding         (outstanding),
      .checked             (checked),
      .popped              (popped),
      .immediates          (immediates)
   );

   // abort when no beat moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_wr_en) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // present one request and hold it until the block takes it
   task automatic send(logic [1:0] fn, logic [ID_W-1:0] id,
                       logic [PRIORITY_BITS-1:0] lvl, logic signed [RUN_W-1:0] caller);
      @(negedge clock);
      start               <= 1'b1;
      req_func            <= fn;
      req_event_id        <= id;
      req_priority_req    <= lvl;
      req_caller_priority <= caller;
      do @(posedge clock); while (busy);
      n_sent++;
   endtask

   // drop start and put junk on the request fields
   task automatic rest(int cycles);
      @(negedge clock);
      start               <= 1'b0;
      req_func            <= 2'($urandom_range(0, 3));
      req_event_id        <= ID_W'($urandom_range(0, ID_COUNT - 1));
      req_priority_req    <= PRIORITY_BITS'($urandom);
      req_caller_priority <= RUN_W'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_immed(logic [PRIORITY_BITS-1:0] lvl);
      settle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= lvl;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      immed_now = lvl;
      n_levels++;
   endtask

   function automatic logic [PRIORITY_BITS-1:0] pick_level();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return immed_now;
      if (narrow) return band_base + PRIORITY_BITS'($urandom_range(0, 3));
      return PRIORITY_BITS'($urandom_range(0, 255));
   endfunction

   // post every id once in shuffled order so the store ends up full
   task automatic fill_store();
      int                       order [ID_COUNT];
      int                       j;
      int                       tmp;
      logic [PRIORITY_BITS-1:0] lvl;
      for (int i = 0; i < ID_COUNT; i++) order[i] = i;
      for (int i = ID_COUNT - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < ID_COUNT; i++) begin
         lvl = pick_level();
         if (lvl == immed_now) lvl = lvl ^ 8'h01;
         send(FUNC_POST, ID_W'(order[i]), lvl, RUN_W'(-1));
      end
      n_fills++;
   endtask

   task automatic random_beat();
      int                       r;
      logic [1:0]               fn;
      logic signed [RUN_W-1:0]  caller;
      r = $urandom_range(0, 99);
      if (r < post_pct) fn = FUNC_POST;
      else if (r < post_pct + cancel_pct) fn = FUNC_CANCEL;
      else if (r < post_pct + cancel_pct + dispatch_pct) fn = FUNC_DISPATCH;
      else fn = FUNC_RESTORE;
      r = $urandom_range(0, 99);
      if (r < 45) caller = '1;
      else if (r < 70 && fn == FUNC_DISPATCH) caller = RUN_W'($urandom_range(0, 255));
      else caller = RUN_W'($urandom_range(0, 511));
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) rest($urandom_range(1, 19));
      send(fn, ID_W'($urandom_range(0, ID_COUNT - 1)), pick_level(), caller);
   endtask

   initial begin
      logic [PRIORITY_BITS-1:0] immed_plan [PHASES];
      int                       phase_start;
      immed_plan = '{8'd0, 8'd255, 8'($urandom), 8'd128, 8'd1, 8'd254, 8'($urandom), 8'd255};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corners under the reset immediate level
      send(FUNC_RESTORE, 6'd0, 8'd0, RUN_W'(-1));
      send(FUNC_DISPATCH, 6'd0, 8'd0, RUN_W'(-1));     // empty store
      send(FUNC_CANCEL, 6'd9, 8'd0, 9'sd0);            // id never queued
      send(FUNC_POST, 6'd0, 8'd0, 9'sd0);              // lowest level, raises preempt
      send(FUNC_POST, 6'd63, 8'd254, 9'sd0);           // preempt already pending
      send(FUNC_POST, 6'd7, 8'd254, 9'sd0);            // equal level queues behind
      send(FUNC_POST, 6'd63, 8'd10, 9'sd0);            // already queued
      send(FUNC_POST, 6'd20, 8'd255, 9'sd0);           // immediate level
      send(FUNC_DISPATCH, 6'd0, 8'd0, 9'sd254);        // head does not outrank caller
      send(FUNC_DISPATCH, 6'd0, 8'd0, RUN_W'(-256));   // most negative caller
      send(FUNC_POST, 6'd33, 8'd200, 9'sd0);           // below running level
      send(FUNC_RESTORE, 6'd0, 8'd0, 9'sd255);
      send(FUNC_DISPATCH, 6'd0, 8'd0, RUN_W'(-1));
      send(FUNC_RESTORE, 6'd0, 8'd0, RUN_W'(-1));
      send(FUNC_POST, 6'd42, 8'd1, 9'sd0);
      send(FUNC_CANCEL, 6'd42, 8'd0, 9'sd0);           // remove from the middle
      send(FUNC_CANCEL, 6'd42, 8'd0, 9'sd0);           // no longer queued
      send(FUNC_DISPATCH, 6'd0, 8'd0, RUN_W'(-1));
      send(FUNC_DISPATCH, 6'd0, 8'd0, RUN_W'(-1));
      send(FUNC_DISPATCH, 6'd0, 8'd0, RUN_W'(-1));     // drained
      send(FUNC_POST, 6'd1, 8'd128, 9'sd0);
      send(FUNC_CANCEL, 6'd1, 8'd0, 9'sd0);
      send(FUNC_RESTORE, 6'd0, 8'd0, RUN_W'(-86));     // negative below idle
      send(FUNC_DISPATCH, 6'd0, 8'd0, 9'sd171);

      for (int phase = 0; phase < PHASES; phase++) begin
         set_immed(immed_plan[phase]);
         narrow    = phase[0];
         band_base = PRIORITY_BITS'($urandom_range(0, 252));
         case (phase % 4)
            0: begin post_pct = 55; cancel_pct = 15; dispatch_pct = 25; end
            1: begin post_pct = 70; cancel_pct = 10; dispatch_pct = 15; end
            2: begin post_pct = 35; cancel_pct = 20; dispatch_pct = 40; end
            default: begin post_pct = 45; cancel_pct = 25; dispatch_pct = 20; end
         endcase
         phase_start = n_sent;
         if (phase == 0 || phase == 4 || phase == 6) fill_store();
         while (n_sent - phase_start < PHASE_ITEMS) begin
            // change the gap rate now and then; the final phase runs back to back
            if ((n_sent - phase_start) % 40 == 0)
               idle_pct = (phase == PHASES - 1) ? 0 : $urandom_range(0, 2) * 15;
            random_beat();
         end
      end

      settle();
      repeat (10) @(posedge clock);
      $display("%0d requests, %0d responses checked, %0d dispatched, %0d immediate posts",
               n_sent, checked, popped, immediates);
      $display("%0d immediate-level settings, %0d passes filling the store to capacity",
               n_levels, n_fills);
      if (error_count == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/pes_pkg.sv
hdl/pes_store.sv
hdl/priority_event_scheduler_unit.sv
bench/pes_queue_checker.sv
bench/testbench.sv
